// ----- hw/rtl/mtt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_pkg
// shared types, codes and helper functions of the markup tag tokenizer
// ----------------------------------------------------------------------------
package mtt_pkg;

    // longest entity name held for decoding or literal replay
    localparam int ENTITY_NAME_MAX = 31;
    localparam int ENT_CW = $clog2(ENTITY_NAME_MAX + 1);
    localparam int ENT_IW = $clog2(ENTITY_NAME_MAX);

    typedef enum logic [2:0] {
        MODE_BODY    = 3'd0,
        MODE_TAG     = 3'd1,
        MODE_HEAD    = 3'd2,
        MODE_COMMENT = 3'd3,
        MODE_CDATA   = 3'd4,
        MODE_PI      = 3'd5,
        MODE_DECL    = 3'd6
    } t_mode;

    typedef enum logic [3:0] {
        K_WORD      = 4'd0,
        K_SPACE     = 4'd1,
        K_TSTART    = 4'd2,
        K_TEND      = 4'd3,
        K_ATTR      = 4'd4,
        K_COMMENT_S = 4'd5,
        K_COMMENT_E = 4'd6,
        K_CDATA_S   = 4'd7,
        K_CDATA_E   = 4'd8,
        K_PI_S      = 4'd9,
        K_PI_E      = 4'd10,
        K_DECL_S    = 4'd11,
        K_DECL_E    = 4'd12,
        K_DATA      = 4'd13,
        K_ERROR     = 4'd14,
        K_EOF       = 4'd15
    } t_kind;

    typedef enum logic [1:0] {
        F_NONE = 2'd0,
        F_TAG  = 2'd1,
        F_ATTR = 2'd2,
        F_VAL  = 2'd3
    } t_field;

    // run classes of body text
    localparam logic [1:0] RUN_NONE  = 2'd0;
    localparam logic [1:0] RUN_WORD  = 2'd1;
    localparam logic [1:0] RUN_SPACE = 2'd2;

    // where an entity was opened
    localparam logic [1:0] ECTX_NONE = 2'd0;
    localparam logic [1:0] ECTX_BODY = 2'd1;
    localparam logic [1:0] ECTX_DQ   = 2'd2;
    localparam logic [1:0] ECTX_SQ   = 2'd3;

    // tag name phases
    localparam logic [2:0] TPH_FIRST    = 3'd0;
    localparam logic [2:0] TPH_NAME     = 3'd1;
    localparam logic [2:0] TPH_CLOSE_WS = 3'd2;

    // head phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_ANAME = 3'd1;
    localparam logic [2:0] PH_AWAIT = 3'd2;
    localparam logic [2:0] PH_AEQ   = 3'd3;
    localparam logic [2:0] PH_DQ    = 3'd4;
    localparam logic [2:0] PH_SQ    = 3'd5;
    localparam logic [2:0] PH_BARE  = 3'd6;
    localparam logic [2:0] PH_SLASH = 3'd7;

    // section openers, first byte in the low bits
    localparam logic [23:0] NAME_COMMENT = "--!";
    localparam logic [63:0] NAME_CDATA   = "[ATADC[!";
    localparam logic [55:0] NAME_ENTITY  = "YTITNE!";

    typedef struct packed {
        t_kind       kind;
        t_field      field;
        logic [7:0]  text;
        logic        has;
        logic        done;
    } t_res;

    typedef struct packed {
        t_mode              mode;
        logic [2:0]         phase;
        logic [1:0]         run;
        logic               closing;
        logic [63:0]        prefix;
        logic [3:0]         nlen;
        logic [ENT_CW-1:0]  ecount;
        logic [1:0]         ectx;
        logic [3:0][7:0]    ehead;
        logic [15:0]        held;
        logic [1:0]         hcount;
        logic               parity;
    } t_state;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == " ") || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D) || (b == 8'h0C);
    endfunction

    function automatic logic is_alnum(input logic [7:0] b);
        return ((b >= "0") && (b <= "9")) || ((b >= "a") && (b <= "z")) ||
               ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic t_res mk_res(input t_kind k, input t_field f, input logic [7:0] t,
                                    input logic h, input logic d);
        t_res r;
        r.kind  = k;
        r.field = f;
        r.text  = t;
        r.has   = h;
        r.done  = d;
        return r;
    endfunction

    function automatic t_state st_reset();
        t_state s;
        s.mode    = MODE_BODY;
        s.phase   = 3'd0;
        s.run     = RUN_NONE;
        s.closing = 1'b0;
        s.prefix  = 64'd0;
        s.nlen    = 4'd0;
        s.ecount  = '0;
        s.ectx    = ECTX_NONE;
        s.ehead   = '0;
        s.held    = 16'd0;
        s.hcount  = 2'd0;
        s.parity  = 1'b0;
        return s;
    endfunction

    function automatic t_state to_body(input t_state s);
        t_state r;
        r       = s;
        r.mode  = MODE_BODY;
        r.phase = 3'd0;
        r.run   = RUN_NONE;
        return r;
    endfunction

    // decoded byte of a known entity, zero when unknown
    function automatic logic [7:0] ent_decode(input logic [3:0][7:0] h,
                                              input logic [ENT_CW-1:0] n);
        logic [7:0] d;
        d = 8'd0;
        if (n == ENT_CW'(2) && h[0] == "g" && h[1] == "t") d = ">";
        else if (n == ENT_CW'(2) && h[0] == "l" && h[1] == "t") d = "<";
        else if (n == ENT_CW'(3) && h[0] == "a" && h[1] == "m" && h[2] == "p") d = "&";
        else if (n == ENT_CW'(4) && h[0] == "a" && h[1] == "p" && h[2] == "o" && h[3] == "s")
            d = "'";
        else if (n == ENT_CW'(4) && h[0] == "q" && h[1] == "u" && h[2] == "o" && h[3] == "t")
            d = "\"";
        return d;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mtt_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_out_stage
// holding register and output register for result requests
// ----------------------------------------------------------------------------
module mtt_out_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_res_valid,
    input  wire mtt_pkg::t_res i_res,
    input  wire logic          i_finish,
    output logic               o_can_emit,
    output logic               o_tvalid,
    input  wire logic          i_tready,
    output logic [15:0]        o_tdata,   // text_byte[7:0], has_text[8], token_done[9]
    output logic [5:0]         o_tuser,   // token_kind[3:0], text_field[5:4]
    output logic               o_tlast
);
    import mtt_pkg::*;

    logic r_pv;   // holding register full
    logic r_pk;   // held request known to be last of its byte
    t_res r_p;
    logic r_ov;
    logic r_ol;
    t_res r_o;

    logic out_free;
    logic move;

    assign out_free   = !r_ov || i_tready;
    assign o_can_emit = !r_pv || out_free;
    // a new request always pushes the held one on
    assign move = r_pv && (i_res_valid || (r_pk && out_free));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_pk <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (move) begin
                r_ov <= 1'b1;
                r_o  <= r_p;
                r_ol <= r_pk;
            end else if (i_tready) begin
                r_ov <= 1'b0;
            end
            if (i_res_valid) begin
                r_pv <= 1'b1;
                r_p  <= i_res;
                r_pk <= i_finish;
            end else if (move) begin
                r_pv <= 1'b0;
            end else if (i_finish && r_pv) begin
                r_pk <= 1'b1;
            end
        end
    end

    assign o_tvalid = r_ov;
    assign o_tdata  = {6'd0, r_o.done, r_o.has, r_o.text};
    assign o_tuser  = {r_o.field, r_o.kind};
    assign o_tlast  = r_ol;

endmodule
`default_nettype wire

// ----- hw/rtl/mtt_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_engine
// tokenizer state, entity name store and the per-byte step logic
// ----------------------------------------------------------------------------
module mtt_engine (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_can_emit,
    output mtt_pkg::t_res      o_res,
    output logic               o_res_valid,
    output logic               o_finish
);
    import mtt_pkg::*;

    typedef enum logic [2:0] {
        SUB_RUN,
        SUB_FL9,
        SUB_EOF,
        SUB_SECEND,
        SUB_ENTLIT
    } t_sub;

    t_state             r_st,   n_st;
    t_sub               r_sub,  n_sub;
    logic [ENT_IW-1:0]  r_lidx, n_lidx;
    logic [7:0]         mem [ENTITY_NAME_MAX];
    logic [7:0]         r_rdata;

    logic               req;
    logic               fin;
    logic               we;
    t_res               res;
    logic               adv;
    logic               ws;
    t_kind              tkind;
    t_kind              ekind;
    t_kind              skind;
    logic [63:0]        np;
    logic [3:0]         nl;
    logic               flushing;
    logic [7:0]         mark;
    logic [1:0]         need;
    logic [7:0]         dec;
    logic [ENT_IW-1:0]  rd_idx;

    always_comb begin
        n_st   = r_st;
        n_sub  = r_sub;
        n_lidx = r_lidx;
        req    = 1'b0;
        fin    = 1'b0;
        we     = 1'b0;
        res    = mk_res(K_WORD, F_NONE, 8'd0, 1'b0, 1'b0);
        ws     = is_ws(i_byte);
        tkind  = r_st.closing ? K_TEND : K_TSTART;
        ekind  = (r_st.ectx == ECTX_BODY) ? K_WORD : K_ATTR;
        np     = r_st.prefix | (64'(i_byte) << {r_st.nlen[2:0], 3'b000});
        nl     = r_st.nlen + 4'd1;
        flushing = (r_st.nlen != 4'd0) && (r_st.nlen <= 4'd8);
        dec    = ent_decode(r_st.ehead, r_st.ecount);
        mark   = (r_st.mode == MODE_COMMENT) ? "-" : (r_st.mode == MODE_CDATA) ? "]" : "?";
        need   = (r_st.mode == MODE_PI) ? 2'd1 : 2'd2;
        case (r_st.mode)
            MODE_COMMENT: skind = K_COMMENT_E;
            MODE_CDATA:   skind = K_CDATA_E;
            MODE_PI:      skind = K_PI_E;
            default:      skind = K_DECL_E;
        endcase

        unique case (r_sub)
            SUB_EOF: begin
                req   = 1'b1;
                res   = mk_res(K_EOF, F_NONE, 8'd0, 1'b0, 1'b1);
                n_st  = st_reset();
                n_sub = SUB_RUN;
                fin   = 1'b1;
            end
            SUB_SECEND: begin
                req   = 1'b1;
                res   = mk_res(skind, F_NONE, 8'd0, 1'b0, 1'b1);
                n_st  = to_body(r_st);
                n_sub = SUB_RUN;
                fin   = 1'b1;
            end
            SUB_FL9: begin
                req = 1'b1;
                if (r_st.nlen != 4'd0) begin
                    res         = mk_res(tkind, F_TAG, r_st.prefix[7:0], 1'b1, 1'b0);
                    n_st.prefix = r_st.prefix >> 8;
                    n_st.nlen   = r_st.nlen - 4'd1;
                end else begin
                    res       = mk_res(tkind, F_TAG, i_byte, 1'b1, 1'b0);
                    n_st.nlen = 4'd9;
                    n_sub     = SUB_RUN;
                    fin       = 1'b1;
                end
            end
            SUB_ENTLIT: begin
                // replay of an unknown entity name
                req = 1'b1;
                res = mk_res(ekind, F_VAL, r_rdata, 1'b1, 1'b0);
                if ((ENT_CW'(r_lidx) + ENT_CW'(1)) == r_st.ecount) begin
                    n_st.ectx = ECTX_NONE;
                    n_sub     = SUB_RUN;
                end else begin
                    n_lidx = r_lidx + ENT_IW'(1);
                end
            end
            default: begin
                if (r_st.ectx != ECTX_NONE) begin
                    if (is_alnum(i_byte) && (r_st.ecount < ENT_CW'(ENTITY_NAME_MAX))) begin
                        we = 1'b1;
                        if (r_st.ecount < ENT_CW'(4)) n_st.ehead[r_st.ecount[1:0]] = i_byte;
                        n_st.ecount = r_st.ecount + ENT_CW'(1);
                        fin = 1'b1;
                    end else begin
                        req = 1'b1;
                        if (r_st.ectx == ECTX_BODY) n_st.run = RUN_WORD;
                        if (dec != 8'd0) begin
                            res       = mk_res(ekind, F_VAL, dec, 1'b1, 1'b0);
                            n_st.ectx = ECTX_NONE;
                            fin       = (i_byte == ";");
                        end else begin
                            res = mk_res(ekind, F_VAL, "&", 1'b1, 1'b0);
                            if (r_st.ecount == '0) begin
                                n_st.ectx = ECTX_NONE;
                            end else begin
                                n_sub  = SUB_ENTLIT;
                                n_lidx = '0;
                            end
                        end
                    end
                end else begin
                    unique case (r_st.mode)
                        MODE_TAG: begin
                            if (r_st.phase == TPH_CLOSE_WS) begin
                                if (ws) begin
                                    fin = 1'b1;
                                end else if (i_byte == ">") begin
                                    req = 1'b1;
                                    if (flushing) begin
                                        res = mk_res(tkind, F_TAG, r_st.prefix[7:0], 1'b1, 1'b0);
                                        n_st.prefix = r_st.prefix >> 8;
                                        n_st.nlen   = r_st.nlen - 4'd1;
                                    end else begin
                                        res  = mk_res(K_TEND, F_NONE, 8'd0, 1'b0, 1'b1);
                                        n_st = to_body(r_st);
                                        fin  = 1'b1;
                                    end
                                end else begin
                                    req = 1'b1;
                                    res = mk_res(K_ERROR, F_NONE, 8'd0, 1'b0, 1'b1);
                                    if (i_byte == 8'd0) begin
                                        n_sub = SUB_EOF;
                                    end else begin
                                        n_st = to_body(r_st);
                                        fin  = 1'b1;
                                    end
                                end
                            end else if (r_st.phase == TPH_FIRST && i_byte == "/") begin
                                n_st.closing = 1'b1;
                                n_st.phase   = TPH_NAME;
                                fin          = 1'b1;
                            end else begin
                                n_st.phase = TPH_NAME;
                                if (i_byte == 8'd0) begin
                                    req   = 1'b1;
                                    res   = mk_res(K_ERROR, F_NONE, 8'd0, 1'b0, 1'b1);
                                    n_sub = SUB_EOF;
                                end else if (ws || i_byte == "/" || i_byte == ">") begin
                                    if (r_st.closing && ws) begin
                                        n_st.phase = TPH_CLOSE_WS;
                                        fin        = 1'b1;
                                    end else if (r_st.closing && i_byte == "/") begin
                                        req  = 1'b1;
                                        res  = mk_res(K_ERROR, F_NONE, 8'd0, 1'b0, 1'b1);
                                        n_st = to_body(r_st);
                                        fin  = 1'b1;
                                    end else if (flushing) begin
                                        // held name bytes go out one a cycle while the output stage takes them
                                        req = 1'b1;
                                        res = mk_res(tkind, F_TAG, r_st.prefix[7:0], 1'b1, 1'b0);
                                        n_st.prefix = r_st.prefix >> 8;
                                        n_st.nlen   = r_st.nlen - 4'd1;
                                    end else if (r_st.closing) begin
                                        req  = 1'b1;
                                        res  = mk_res(K_TEND, F_NONE, 8'd0, 1'b0, 1'b1);
                                        n_st = to_body(r_st);
                                        fin  = 1'b1;
                                    end else begin
                                        req        = 1'b1;
                                        res        = mk_res(K_TSTART, F_NONE, 8'd0, 1'b0, 1'b1);
                                        n_st.mode  = MODE_HEAD;
                                        n_st.phase = (i_byte == "/") ? PH_SLASH : PH_IDLE;
                                        if (i_byte == ">") n_st = to_body(n_st);
                                        fin        = 1'b1;
                                    end
                                end else if (r_st.nlen < 4'd8) begin
                                    n_st.prefix = np;
                                    n_st.nlen   = nl;
                                    fin         = 1'b1;
                                    if ((nl == 4'd3 && np[23:0] == NAME_COMMENT) ||
                                        (nl == 4'd8 && np == NAME_CDATA) ||
                                        (nl == 4'd7 && np[55:0] == NAME_ENTITY) ||
                                        (nl == 4'd1 && i_byte == "?")) begin
                                        req = 1'b1;
                                        n_st.phase  = 3'd0;
                                        n_st.held   = 16'd0;
                                        n_st.hcount = 2'd0;
                                        n_st.parity = 1'b0;
                                        if (nl == 4'd3) begin
                                            n_st.mode = MODE_COMMENT;
                                            res = mk_res(K_COMMENT_S, F_NONE, 8'd0, 1'b0, 1'b1);
                                        end else if (nl == 4'd8) begin
                                            n_st.mode = MODE_CDATA;
                                            res = mk_res(K_CDATA_S, F_NONE, 8'd0, 1'b0, 1'b1);
                                        end else if (nl == 4'd7) begin
                                            n_st.mode = MODE_DECL;
                                            res = mk_res(K_DECL_S, F_NONE, 8'd0, 1'b0, 1'b1);
                                        end else begin
                                            n_st.mode = MODE_PI;
                                            res = mk_res(K_PI_S, F_NONE, 8'd0, 1'b0, 1'b1);
                                        end
                                    end
                                end else if (r_st.nlen == 4'd8) begin
                                    // ninth name byte: drain the held prefix first
                                    req         = 1'b1;
                                    res = mk_res(tkind, F_TAG, r_st.prefix[7:0], 1'b1, 1'b0);
                                    n_st.prefix = r_st.prefix >> 8;
                                    n_st.nlen   = 4'd7;
                                    n_sub       = SUB_FL9;
                                end else begin
                                    req = 1'b1;
                                    res = mk_res(tkind, F_TAG, i_byte, 1'b1, 1'b0);
                                    fin = 1'b1;
                                end
                            end
                        end
                        MODE_HEAD: begin
                            case (r_st.phase)
                                PH_ANAME: begin
                                    if (i_byte == "=") begin
                                        n_st.phase = PH_AEQ;
                                        fin = 1'b1;
                                    end else if (i_byte == 8'd0) begin
                                        req = 1'b1;
                                        res = mk_res(K_ERROR, F_NONE, 8'd0, 1'b0, 1'b1);
                                        n_sub = SUB_EOF;
                                    end else if (i_byte == ">") begin
                                        req = 1'b1;
                                        res = mk_res(K_ATTR, F_NONE, 8'd0, 1'b0, 1'b1);
                                        n_st = to_body(r_st);
                                        fin = 1'b1;
                                    end else if (ws) begin
                                        n_st.phase = PH_AWAIT;
                                        fin = 1'b1;
                                    end else if (i_byte == "<") begin
                                        req = 1'b1;
                                        res = mk_res(K_ERROR, F_NONE, 8'd0, 1'b0, 1'b1);
                                        n_st.phase = PH_IDLE;
                                        fin = 1'b1;
                                    end else begin
                                        req = 1'b1;
                                        res = mk_res(K_ATTR, F_ATTR, i_byte, 1'b1, 1'b0);
                                        fin = 1'b1;
                                    end
                                end
                                PH_AWAIT: begin
                                    if (ws) begin
                                        fin = 1'b1;
                                    end else if (i_byte == "=") begin
                                        n_st.phase = PH_AEQ;
                                        fin = 1'b1;
                                    end else begin
                                        // close the bare name, then look at the byte again
                                        req = 1'b1;
                                        res = mk_res(K_ATTR, F_NONE, 8'd0, 1'b0, 1'b1);
                                        n_st.phase = PH_IDLE;
                                    end
                                end
                                PH_AEQ: begin
                                    if (ws) begin
                                        fin = 1'b1;
                                    end else if (i_byte == "\"") begin
                                        n_st.phase = PH_DQ;
                                        fin = 1'b1;
                                    end else if (i_byte == "'") begin
                                        n_st.phase = PH_SQ;
                                        fin = 1'b1;
                                    end else if (i_byte == 8'd0) begin
                                        req = 1'b1;
                                        res = mk_res(K_ERROR, F_NONE, 8'd0, 1'b0, 1'b1);
                                        n_sub = SUB_EOF;
                                    end else if (i_byte == ">") begin
                                        req = 1'b1;
                                        res = mk_res(K_ATTR, F_NONE, 8'd0, 1'b0, 1'b1);
                                        n_st = to_body(r_st);
                                        fin = 1'b1;
                                    end else begin
                                        req = 1'b1;
                                        res = mk_res(K_ATTR, F_VAL, i_byte, 1'b1, 1'b0);
                                        n_st.phase = PH_BARE;
                                        fin = 1'b1;
                                    end
                                end
                                PH_DQ, PH_SQ: begin
                                    if (i_byte == ((r_st.phase == PH_DQ) ? "\"" : "'")) begin
                                        req = 1'b1;
                                        res = mk_res(K_ATTR, F_NONE, 8'd0, 1'b0, 1'b1);
                                        n_st.phase = PH_IDLE;
                                        fin = 1'b1;
                                    end else if (i_byte == 8'd0) begin
                                        req = 1'b1;
                                        res = mk_res(K_ERROR, F_NONE, 8'd0, 1'b0, 1'b1);
                                        n_sub = SUB_EOF;
                                    end else if (i_byte == "&") begin
                                        n_st.ectx   = (r_st.phase == PH_DQ) ? ECTX_DQ : ECTX_SQ;
                                        n_st.ecount = '0;
                                        fin = 1'b1;
                                    end else begin
                                        req = 1'b1;
                                        res = mk_res(K_ATTR, F_VAL, i_byte, 1'b1, 1'b0);
                                        fin = 1'b1;
                                    end
                                end
                                PH_BARE: begin
                                    if (ws) begin
                                        req = 1'b1;
                                        res = mk_res(K_ATTR, F_NONE, 8'd0, 1'b0, 1'b1);
                                        n_st.phase = PH_IDLE;
                                        fin = 1'b1;
                                    end else if (i_byte == ">") begin
                                        req = 1'b1;
                                        res = mk_res(K_ATTR, F_NONE, 8'd0, 1'b0, 1'b1);
                                        n_st = to_body(r_st);
                                        fin = 1'b1;
                                    end else if (i_byte == 8'd0) begin
                                        req = 1'b1;
                                        res = mk_res(K_ERROR, F_NONE, 8'd0, 1'b0, 1'b1);
                                        n_sub = SUB_EOF;
                                    end else begin
                                        req = 1'b1;
                                        res = mk_res(K_ATTR, F_VAL, i_byte, 1'b1, 1'b0);
                                        fin = 1'b1;
                                    end
                                end
                                PH_SLASH: begin
                                    req = 1'b1;
                                    if (i_byte == ">") begin
                                        res = mk_res(K_TEND, F_NONE, 8'd0, 1'b0, 1'b1);
                                        n_st = to_body(r_st);
                                        fin = 1'b1;
                                    end else begin
                                        // error, then the byte is taken as head input
                                        res = mk_res(K_ERROR, F_NONE, 8'd0, 1'b0, 1'b1);
                                        n_st.phase = PH_IDLE;
                                    end
                                end
                                default: begin
                                    n_st.phase = PH_IDLE;
                                    fin = 1'b1;
                                    if (ws) begin
                                        n_st.phase = PH_IDLE;
                                    end else if (i_byte == ">") begin
                                        n_st = to_body(r_st);
                                    end else if (i_byte == "/") begin
                                        n_st.phase = PH_SLASH;
                                    end else if (i_byte == 8'd0) begin
                                        req  = 1'b1;
                                        res  = mk_res(K_EOF, F_NONE, 8'd0, 1'b0, 1'b1);
                                        n_st = st_reset();
                                    end else if (i_byte == "<") begin
                                        req = 1'b1;
                                        res = mk_res(K_ERROR, F_NONE, 8'd0, 1'b0, 1'b1);
                                    end else if (i_byte == "=") begin
                                        n_st.phase = PH_AEQ;
                                    end else begin
                                        req = 1'b1;
                                        res = mk_res(K_ATTR, F_ATTR, i_byte, 1'b1, 1'b0);
                                        n_st.phase = PH_ANAME;
                                    end
                                end
                            endcase
                        end
                        MODE_COMMENT, MODE_CDATA, MODE_PI: begin
                            if (i_byte == 8'd0) begin
                                req   = 1'b1;
                                res   = mk_res(K_ERROR, F_NONE, 8'd0, 1'b0, 1'b1);
                                n_sub = SUB_EOF;
                            end else if (i_byte == ">" && r_st.hcount == need) begin
                                req   = 1'b1;
                                res   = mk_res(K_DATA, F_NONE, 8'd0, 1'b0, 1'b1);
                                n_sub = SUB_SECEND;
                            end else if (i_byte == mark) begin
                                if (r_st.hcount < need) begin
                                    n_st.hcount = r_st.hcount + 2'd1;
                                end else begin
                                    req = 1'b1;
                                    res = mk_res(K_DATA, F_VAL,
                                                 (need == 2'd2) ? r_st.held[15:8] : r_st.held[7:0],
                                                 1'b1, 1'b0);
                                end
                                n_st.held = {r_st.held[7:0], i_byte};
                                fin = 1'b1;
                            end else if (r_st.hcount != 2'd0) begin
                                // give back the held closing-mark bytes, oldest first
                                req = 1'b1;
                                res = mk_res(K_DATA, F_VAL,
                                             (r_st.hcount == 2'd2) ? r_st.held[15:8] :
                                                                     r_st.held[7:0],
                                             1'b1, 1'b0);
                                n_st.hcount = r_st.hcount - 2'd1;
                            end else begin
                                req       = 1'b1;
                                res       = mk_res(K_DATA, F_VAL, i_byte, 1'b1, 1'b0);
                                n_st.held = 16'd0;
                                fin       = 1'b1;
                            end
                        end
                        MODE_DECL: begin
                            req = 1'b1;
                            if (i_byte == 8'd0) begin
                                res   = mk_res(K_ERROR, F_NONE, 8'd0, 1'b0, 1'b1);
                                n_sub = SUB_EOF;
                            end else if (i_byte == ">" && !r_st.parity) begin
                                res   = mk_res(K_DATA, F_NONE, 8'd0, 1'b0, 1'b1);
                                n_sub = SUB_SECEND;
                            end else begin
                                if (i_byte == "\"") n_st.parity = !r_st.parity;
                                res = mk_res(K_DATA, F_VAL, i_byte, 1'b1, 1'b0);
                                fin = 1'b1;
                            end
                        end
                        default: begin
                            n_st.mode = MODE_BODY;
                            if (i_byte == 8'd0) begin
                                req = 1'b1;
                                if (r_st.run != RUN_NONE) begin
                                    res = mk_res((r_st.run == RUN_SPACE) ? K_SPACE : K_WORD,
                                                 F_NONE, 8'd0, 1'b0, 1'b1);
                                    n_st.run = RUN_NONE;
                                    n_sub    = SUB_EOF;
                                end else begin
                                    res  = mk_res(K_EOF, F_NONE, 8'd0, 1'b0, 1'b1);
                                    n_st = st_reset();
                                    fin  = 1'b1;
                                end
                            end else if (i_byte == "<" || i_byte == "&") begin
                                req = (r_st.run != RUN_NONE);
                                res = mk_res((r_st.run == RUN_SPACE) ? K_SPACE : K_WORD,
                                             F_NONE, 8'd0, 1'b0, 1'b1);
                                n_st.run = RUN_NONE;
                                if (i_byte == "<") begin
                                    n_st.mode    = MODE_TAG;
                                    n_st.phase   = TPH_FIRST;
                                    n_st.closing = 1'b0;
                                    n_st.nlen    = 4'd0;
                                    n_st.prefix  = 64'd0;
                                end else begin
                                    n_st.ectx   = ECTX_BODY;
                                    n_st.ecount = '0;
                                end
                                fin = 1'b1;
                            end else if (r_st.run != RUN_NONE &&
                                         r_st.run != (ws ? RUN_SPACE : RUN_WORD)) begin
                                // class change: close the run and look again
                                req = 1'b1;
                                res = mk_res((r_st.run == RUN_SPACE) ? K_SPACE : K_WORD,
                                             F_NONE, 8'd0, 1'b0, 1'b1);
                                n_st.run = RUN_NONE;
                            end else begin
                                req      = 1'b1;
                                res      = mk_res(ws ? K_SPACE : K_WORD, F_VAL, i_byte,
                                                  1'b1, 1'b0);
                                n_st.run = ws ? RUN_SPACE : RUN_WORD;
                                fin      = 1'b1;
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    assign adv    = i_valid && (!req || i_can_emit);
    assign rd_idx = adv ? n_lidx : r_lidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= st_reset();
            r_sub  <= SUB_RUN;
            r_lidx <= '0;
        end else if (adv) begin
            r_st   <= n_st;
            r_sub  <= n_sub;
            r_lidx <= n_lidx;
        end
    end

    // entity name store
    always_ff @(posedge i_clk) begin
        if (adv && we) mem[r_st.ecount[ENT_IW-1:0]] <= i_byte;
        r_rdata <= mem[rd_idx];
    end

    assign o_res       = res;
    assign o_res_valid = adv && req;
    assign o_finish    = adv && fin;

endmodule
`default_nettype wire

// ----- hw/rtl/markup_tag_tokenizer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// markup_tag_tokenizer
// streaming html/xml tokenizer, one document byte in, token requests out
// ----------------------------------------------------------------------------
// Bytes arrive on the slave stream, byte 0 ending the document; token
// requests leave on the master stream, one text byte or one start, end,
// error or eof mark per request, tlast on the final request caused by a
// byte. A new byte is taken in the cycle in which the one before it is done.
// The step logic emits at most one request a cycle, none while stalled, so
// a byte is done only once every request it causes is emitted. Several
// requests come from a flush of up to eight held tag name bytes (nine
// requests when a ninth name byte arrives), the replay of an unknown
// entity ('&' plus up to 31 stored name bytes read one a cycle from the
// name store, unless stalled), given-back closing-mark bytes in comment,
// cdata and pi text, and the error or close request ahead of an eof. A
// byte that first closes something (a word/space run on a class change,
// an attribute name not followed by '=', a stray byte after '/' in a
// head, a decoded or unknown entity) is looked at again once that close
// is emitted (for an unknown entity, after the replay). A stalled
// receiver holds the step logic once the output stage is full. No reset
// sweep is needed.
// ----------------------------------------------------------------------------
module markup_tag_tokenizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // in_byte[7:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // text_byte[7:0], has_text[8], token_done[9]
    output logic [5:0]       m_axis_tuser,   // token_kind[3:0], text_field[5:4]
    output logic             m_axis_tlast
);
    import mtt_pkg::*;

    // input register
    logic       r_bv;
    logic [7:0] r_byte;

    // step logic to output stage
    t_res       res;
    logic       res_valid;
    logic       finish;
    logic       can_emit;

    // a new byte enters when none is held or the held one is done this cycle
    assign s_axis_tready = !r_bv || finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_bv   <= 1'b1;
            r_byte <= s_axis_tdata;
        end else if (finish) begin
            r_bv <= 1'b0;
        end
    end

    mtt_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_bv),
        .i_byte      (r_byte),
        .i_can_emit  (can_emit),
        .o_res       (res),
        .o_res_valid (res_valid),
        .o_finish    (finish)
    );

    // holding stage settles tlast once the byte is known to be done
    mtt_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_finish    (finish),
        .o_can_emit  (can_emit),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tuser     (m_axis_tuser),
        .o_tlast     (m_axis_tlast)
    );

endmodule
`default_nettype wire
